[rtl/core/fdt_pkg.sv]
// fdt_pkg: shared types, codes and helpers for the frame damage tracker
// no dependencies; imported by every module of the block
package fdt_pkg;

   // operation codes carried in the request tuser
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FULL  = 1'b1;

   localparam logic [31:0] WHITE_OPAQUE = 32'hFFFF_FFFF;
   localparam logic [31:0] BLACK_OPAQUE = 32'hFF00_0000;

   localparam int REQ_DATA_W = 48;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 40;

   typedef struct packed {
      logic        op;
      logic [7:0]  pos_x;
      logic [7:0]  pos_y;
      logic [31:0] color;
      logic        first;
      logic        last;
      logic        in_frame;
   } item_type;

   typedef struct packed {
      logic       full_refresh;
      logic       colour_seen;
      logic [7:0] box_max_y;
      logic [7:0] box_max_x;
      logic [7:0] box_min_y;
      logic [7:0] box_min_x;
      logic       any_changed;
   } rsp_type;

   // not white, not opaque black, and red/green/blue not all equal
   function automatic logic is_coloured(input logic [31:0] c);
      logic grey;
      grey = (c[23:16] == c[15:8]) && (c[15:8] == c[7:0]);
      return (c != WHITE_OPAQUE) && (c != BLACK_OPAQUE) && !grey;
   endfunction

endpackage

[rtl/core/fdt_store.sv]
// fdt_store: frame store memory with registered read, write-to-read bypass
// and the clearing sweep after reset; uses fdt_pkg
module fdt_store #(
   parameter int DEPTH  = 65536,
   parameter int ADDR_W = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [31:0]       wr_data,
   output logic [31:0]       rd_data,
   output logic              ready
);
   import fdt_pkg::*;

   logic [31:0]       mem [DEPTH];
   logic [31:0]       rd_q_ff;
   logic              fwd_hit_ff;
   logic [31:0]       fwd_data_ff;
   logic              clearing_ff;
   logic              clearing_in;
   logic [ADDR_W-1:0] clr_addr_ff;
   logic [ADDR_W-1:0] clr_addr_in;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [31:0]       mem_wdata;

   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   assign mem_we    = clearing_ff || wr_en;
   assign mem_waddr = clearing_ff ? clr_addr_ff : wr_addr;
   assign mem_wdata = clearing_ff ? 32'h0 : wr_data;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_q_ff <= mem[rd_addr];
      end
   end

   // a write landing in the same cycle as a read of that entry is bypassed
   always_ff @(posedge clock) begin
      if (rd_en) begin
         fwd_hit_ff  <= wr_en && (wr_addr == rd_addr);
         fwd_data_ff <= wr_data;
      end
   end

   assign rd_data = fwd_hit_ff ? fwd_data_ff : rd_q_ff;
   assign ready   = !clearing_ff;

endmodule

[rtl/core/fdt_track.sv]
// fdt_track: per-area accumulators (changed, colour, bounding box) and the
// pending full-refresh flag; builds the result; uses fdt_pkg
module fdt_track (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  fdt_pkg::item_type    item,
   input  logic [31:0]          stored,
   output logic                 res_valid,
   output fdt_pkg::rsp_type     res
);
   import fdt_pkg::*;

   logic       changed_ff, changed_in;
   logic       colour_ff, colour_in;
   logic       pending_ff, pending_in;
   logic [7:0] min_x_ff, min_y_ff, max_x_ff, max_y_ff;
   logic [7:0] min_x_in, min_y_in, max_x_in, max_y_in;
   logic       base_changed, base_colour, diff, area_changed, area_colour;
   logic [7:0] nmin_x, nmin_y, nmax_x, nmax_y;

   always_comb begin
      base_changed = changed_ff && !item.first;
      base_colour  = colour_ff && !item.first;
      diff         = item.in_frame && (stored != item.color);
      area_changed = base_changed || diff;
      area_colour  = base_colour || (diff && is_coloured(item.color));

      nmin_x = min_x_ff;
      nmin_y = min_y_ff;
      nmax_x = max_x_ff;
      nmax_y = max_y_ff;
      if (diff) begin
         if (!base_changed) begin
            nmin_x = item.pos_x;
            nmin_y = item.pos_y;
            nmax_x = item.pos_x;
            nmax_y = item.pos_y;
         end else begin
            if (item.pos_x < min_x_ff) nmin_x = item.pos_x;
            if (item.pos_y < min_y_ff) nmin_y = item.pos_y;
            if (item.pos_x > max_x_ff) nmax_x = item.pos_x;
            if (item.pos_y > max_y_ff) nmax_y = item.pos_y;
         end
      end

      res = '0;
      if (area_changed) begin
         res.any_changed  = 1'b1;
         res.box_min_x    = nmin_x;
         res.box_min_y    = nmin_y;
         res.box_max_x    = nmax_x;
         res.box_max_y    = nmax_y;
         res.colour_seen  = area_colour;
         res.full_refresh = pending_ff;
      end
      res_valid = step && (item.op == OP_PIXEL) && item.last;

      changed_in = changed_ff;
      colour_in  = colour_ff;
      pending_in = pending_ff;
      min_x_in   = min_x_ff;
      min_y_in   = min_y_ff;
      max_x_in   = max_x_ff;
      max_y_in   = max_y_ff;
      if (step) begin
         if (item.op == OP_FULL) begin
            pending_in = 1'b1;
         end else if (item.last) begin
            changed_in = 1'b0;
            colour_in  = 1'b0;
            min_x_in   = '0;
            min_y_in   = '0;
            max_x_in   = '0;
            max_y_in   = '0;
            if (area_changed) pending_in = 1'b0;
         end else begin
            changed_in = area_changed;
            colour_in  = area_colour;
            min_x_in   = nmin_x;
            min_y_in   = nmin_y;
            max_x_in   = nmax_x;
            max_y_in   = nmax_y;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         changed_ff <= 1'b0;
         colour_ff  <= 1'b0;
         pending_ff <= 1'b0;
      end else begin
         changed_ff <= changed_in;
         colour_ff  <= colour_in;
         pending_ff <= pending_in;
      end
      min_x_ff <= min_x_in;
      min_y_ff <= min_y_in;
      max_x_ff <= max_x_in;
      max_y_ff <= max_y_in;
   end

endmodule

[rtl/core/framebuffer_damage_tracker.sv]
// framebuffer_damage_tracker: one pixel per cycle when not stalled, two stages (store
// read, then compare/write-back/accumulate). throughput is set by the single read and
// single write port of the frame store; back-to-back pixels to one entry are bypassed,
// so stage 1 stalls only on an area end while the output register is full. after reset
// the store is swept to zero, one entry per cycle over FRAME_WIDTH*FRAME_HEIGHT entries
// (65536 by default) with req_tready low. depends on fdt_pkg, fdt_store, fdt_track
module framebuffer_damage_tracker #(
   parameter int FRAME_WIDTH  = 256,
   parameter int FRAME_HEIGHT = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [fdt_pkg::REQ_DATA_W-1:0] req_tdata,  // pos_x, pos_y, pixel_color
   input  logic [fdt_pkg::REQ_USER_W-1:0] req_tuser,  // operation, first_in_area
   input  logic                           req_tlast,  // last_in_area
   // result channel
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // any_changed, box_min_x, box_min_y, box_max_x, box_max_y, colour_seen,
   // full_refresh, then zero padding
   output logic [fdt_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import fdt_pkg::*;

   localparam int DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
   localparam int ADDR_W = $clog2(DEPTH);

   // stage 0: decode the incoming transaction and form the store address
   logic              req_fire;
   item_type          s0_item;
   logic [ADDR_W-1:0] s0_addr;

   // stage 1: stored word is back, compare and write back
   logic              s1_valid_ff, s1_valid_in;
   item_type          s1_item_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic              s1_advance;
   logic              s1_step;
   logic              s1_wr;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff;
   rsp_type           res;
   logic              res_valid;
   logic              store_ready;
   logic [31:0]       stored;

   always_comb begin
      s0_item.op       = req_tuser[0];
      s0_item.first    = req_tuser[1];
      s0_item.last     = req_tlast;
      s0_item.pos_x    = req_tdata[7:0];
      s0_item.pos_y    = req_tdata[15:8];
      s0_item.color    = req_tdata[47:16];
      s0_item.in_frame = (32'(s0_item.pos_x) < FRAME_WIDTH) &&
                         (32'(s0_item.pos_y) < FRAME_HEIGHT);
      s0_addr = ADDR_W'(32'(s0_item.pos_y) * FRAME_WIDTH + 32'(s0_item.pos_x));
   end

   // stage 1 only waits when it holds an area end and the output slot is taken
   assign s1_advance = !(s1_item_ff.op == OP_PIXEL && s1_item_ff.last) ||
                       !rsp_valid_ff || rsp_tready;
   assign s1_step    = s1_valid_ff && s1_advance;
   assign s1_wr      = s1_step && (s1_item_ff.op == OP_PIXEL) && s1_item_ff.in_frame;
   assign req_tready = store_ready && (!s1_valid_ff || s1_advance);
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_fire) begin
         s1_item_ff <= s0_item;
         s1_addr_ff <= s0_addr;
      end
   end

   fdt_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_fire),
      .rd_addr (s0_addr),
      .wr_en   (s1_wr),
      .wr_addr (s1_addr_ff),
      .wr_data (s1_item_ff.color),
      .rd_data (stored),
      .ready   (store_ready)
   );

   fdt_track u_track (
      .clock     (clock),
      .reset     (reset),
      .step      (s1_step),
      .item      (s1_item_ff),
      .stored    (stored),
      .res_valid (res_valid),
      .res       (res)
   );

   // output register: loaded on an area end, drained by the consumer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - $bits(rsp_type))'(0), rsp_ff};

   // no transaction is taken while the store is being swept
   a_no_accept_clearing: assert property (@(posedge clock) disable iff (reset)
      !store_ready |-> !req_tready)
      else $error("request accepted during store sweep");

   // an area end always lands in the output register
   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      res_valid |=> rsp_valid_ff)
      else $error("area result lost");

   // full refresh is only issued together with a change
   a_full_needs_change: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.full_refresh |-> rsp_ff.any_changed)
      else $error("full refresh without change");

   // an unchanged area reports all zero fields
   a_quiet_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.any_changed |-> rsp_tdata == '0)
      else $error("unchanged area with non-zero fields");

endmodule
